### rtl/rv64_pkg.sv
// Shared constants, types and helpers for the RV64IM execute block.
`timescale 1ns / 1ps
package rv64_pkg;
  localparam int XLEN = 64;
  localparam int REG_COUNT = 32;
  localparam int REG_AW = $clog2(REG_COUNT);

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
  localparam logic [6:0] OPC_OPW    = 7'b0111011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  localparam logic [2:0] KIND_RETIRED = 3'd0;
  localparam logic [2:0] KIND_LOAD    = 3'd1;
  localparam logic [2:0] KIND_STORE   = 3'd2;
  localparam logic [2:0] KIND_ILLEGAL = 3'd3;
  localparam logic [2:0] KIND_ECALL   = 3'd4;

  localparam logic [1:0] MD_MUL  = 2'd0;
  localparam logic [1:0] MD_DIVS = 2'd1;
  localparam logic [1:0] MD_DIVU = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] mem_address;
    logic [1:0]  mem_size;
    logic [63:0] store_value;
    logic        dest_write;
    logic [4:0]  dest_index;
    logic [63:0] dest_value;
    logic [63:0] next_address;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [1:0]  mode;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] lo;
    logic [63:0] hi;
  } md_rsp_t;

  function automatic logic [63:0] sext32(input logic [63:0] v);
    sext32 = {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] size_mask(input logic [1:0] sz);
    case (sz)
      2'd0: size_mask = 64'h0000_0000_0000_00FF;
      2'd1: size_mask = 64'h0000_0000_0000_FFFF;
      2'd2: size_mask = 64'h0000_0000_FFFF_FFFF;
      default: size_mask = '1;
    endcase
  endfunction
endpackage

### rtl/rv64_ifc.sv
// Valid/ready channel interfaces for instruction items and result items.
`timescale 1ns / 1ps
interface rv64_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] instr_word;
  logic [63:0] load_data;
  modport source(output valid, op, instr_word, load_data, input ready);
  modport sink(input valid, op, instr_word, load_data, output ready);
endinterface

interface rv64_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] mem_address;
  logic [1:0]  mem_size;
  logic [63:0] store_value;
  logic        dest_write;
  logic [4:0]  dest_index;
  logic [63:0] dest_value;
  logic [63:0] next_address;
  modport source(output valid, kind, mem_address, mem_size, store_value, dest_write,
                 dest_index, dest_value, next_address, input ready);
  modport sink(input valid, kind, mem_address, mem_size, store_value, dest_write,
               dest_index, dest_value, next_address, output ready);
endinterface

### rtl/rv64_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module rv64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### rtl/rv64_muldiv.sv
// Shared iterative unit: radix-2 shift-add multiply and restoring divide.
`timescale 1ns / 1ps
module rv64_muldiv
  import rv64_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);
  // mul: acc holds {hi,lo} product; div: acc holds {rem,quot}
  logic [127:0] acc;
  logic [63:0]  opb;
  logic [1:0]   mode;
  logic [6:0]   cnt;
  logic         busy;
  logic         done;
  logic [64:0]  sum;
  logic [64:0]  diff;

  always_comb begin
    sum  = {1'b0, acc[127:64]} + {1'b0, (acc[0] ? opb : 64'd0)};
    diff = {acc[127:63]} - {1'b0, opb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mode <= req.mode;
        opb  <= req.b;
        acc  <= {64'd0, req.a};
      end else if (busy) begin
        if (mode == MD_MUL) begin
          acc <= {sum, acc[63:1]};
        end else if (!diff[64]) begin
          acc <= {diff[63:0], acc[62:0], 1'b1};
        end else begin
          acc <= {acc[126:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.lo = acc[63:0];
  assign rsp.hi = acc[127:64];
endmodule

### rtl/rv64im_integer_execute.sv
// Top level: decoder, sequencer, register file and result register.
//
// Channel in carries op, instr_word and load_data; channel out carries one
// result item per input item. Configuration is an APB port with one 64-bit
// register, start_address, at byte address 0; a write also loads the PC.
// Every item first reads the register file in ST_READ (registered RAM
// reads), then executes and writes back in ST_EXEC; the result is then held
// in the output register until taken. MUL/DIV/REM forms go on from ST_EXEC
// to ST_MD: 64 steps in the shared shift-add/subtract unit, then the answer
// is fixed up and written back. The high multiply forms are exact for signed
// operands through a correction.
// Input ready is low from acceptance until the result has been taken, so
// a stalled receiver stalls the input side too. Reset (synchronous, rst)
// clears the PC to zero, drops any pending load and empties the output;
// register file entries are cleared by a sweep of all 32 entries after
// reset, during which no item is accepted.
`timescale 1ns / 1ps
module rv64im_integer_execute
  import rv64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rv64_in_if.sink     in_ch,
  rv64_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EXEC  = 3'd3;
  localparam logic [2:0] ST_MD    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state;
  logic [63:0] start_address;
  logic [63:0] prog_counter;
  logic        load_pending;
  logic [4:0]  pending_dest;
  logic [1:0]  pending_size;
  logic        pending_signed;
  logic        op;
  logic [31:0] w;
  logic [63:0] ldata;
  logic [63:0] ldmsb;
  logic [REG_AW-1:0] clr_idx;
  res_t        res, res_next, res_ld;
  logic        md_neg;
  logic        md_hi;
  logic        md_w;
  md_req_t     md_req;
  md_rsp_t     md_rsp;

  logic        rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [63:0] rf_wdata, rs1_raw, rs2_raw, a, b;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? start_address : 64'd0;
  wire cfg_wr = psel && penable && pwrite && (paddr[3] == 1'b0);

  wire [4:0] rs1 = w[19:15];
  wire [4:0] rs2 = w[24:20];
  wire [4:0] rd  = w[11:7];
  rv64_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr_a(rs1[REG_AW-1:0]), .raddr_b(rs2[REG_AW-1:0]),
    .rdata_a(rs1_raw), .rdata_b(rs2_raw)
  );
  assign a = (rs1 == 5'd0 || 32'(rs1) >= REG_COUNT) ? 64'd0 : rs1_raw;
  assign b = (rs2 == 5'd0 || 32'(rs2) >= REG_COUNT) ? 64'd0 : rs2_raw;

  rv64_muldiv u_md (.clk(clk), .rst(rst), .req(md_req), .rsp(md_rsp));

  // decode and execute everything except multiply/divide
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j, opnd, alu_r, pc4;
  logic        bad, has_rd, taken, is_md, alt, lt_s, lt_u;
  logic [5:0]  sh;
  logic [63:0] r64;

  always_comb begin
    opc   = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{52{w[31]}}, w[31:20]};
    imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {{32{w[31]}}, w[31:12], 12'd0};
    imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    pc4   = prog_counter + 64'd4;
    lt_s  = $signed(a) < $signed(b);
    lt_u  = a < b;
    res_next = '0;
    res_next.next_address = pc4;
    bad = 1'b0; has_rd = 1'b0; taken = 1'b0; is_md = 1'b0;
    r64 = 64'd0;
    opnd = (opc == OPC_OPIMM || opc == OPC_OPIMMW) ? imm_i : b;
    alt = (opc == OPC_OP || opc == OPC_OPW) && f7[5];
    if (opc == OPC_OPIMM && f3 == 3'd5) alt = w[30];
    sh = (opc == OPC_OPW || opc == OPC_OPIMMW) ? {1'b0, opnd[4:0]} : opnd[5:0];
    case (f3)
      3'd0: alu_r = alt ? a - opnd : a + opnd;
      3'd1: alu_r = a << sh;
      3'd2: alu_r = {63'd0, $signed(a) < $signed(opnd)};
      3'd3: alu_r = {63'd0, a < opnd};
      3'd4: alu_r = a ^ opnd;
      3'd5: alu_r = alt ? 64'($signed(a) >>> sh) : a >> sh;
      3'd6: alu_r = a | opnd;
      default: alu_r = a & opnd;
    endcase
    case (opc)
      OPC_LUI: begin r64 = imm_u; has_rd = 1'b1; end
      OPC_AUIPC: begin r64 = prog_counter + imm_u; has_rd = 1'b1; end
      OPC_JAL: begin
        r64 = pc4; has_rd = 1'b1;
        res_next.next_address = prog_counter + imm_j;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        r64 = pc4; has_rd = 1'b1;
        res_next.next_address = (a + imm_i) & ~64'd1;
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: taken = a == b;
          3'd1: taken = a != b;
          3'd4: taken = lt_s;
          3'd5: taken = !lt_s;
          3'd6: taken = lt_u;
          3'd7: taken = !lt_u;
          default: bad = 1'b1;
        endcase
        if (taken) res_next.next_address = prog_counter + imm_b;
      end
      OPC_LOAD: begin
        if (f3 == 3'd7) bad = 1'b1;
        res_next.kind = KIND_LOAD;
        res_next.mem_address = a + imm_i;
        res_next.mem_size = f3[1:0];
      end
      OPC_STORE: begin
        if (f3[2]) bad = 1'b1;
        res_next.kind = KIND_STORE;
        res_next.mem_address = a + imm_s;
        res_next.mem_size = f3[1:0];
        res_next.store_value = b & size_mask(f3[1:0]);
      end
      OPC_OPIMM: begin
        has_rd = 1'b1; r64 = alu_r;
        if (f3 == 3'd1 && w[31:26] != 6'd0) bad = 1'b1;
        if (f3 == 3'd5 && w[31:26] != 6'd0 && w[31:26] != 6'h10) bad = 1'b1;
      end
      OPC_OPIMMW: begin
        has_rd = 1'b1;
        if (f3 == 3'd5 && f7 == 7'h20) r64 = sext32(64'($signed(sext32(a)) >>> sh));
        else if (f3 == 3'd5) r64 = sext32({32'd0, a[31:0]} >> sh);
        else r64 = sext32(alu_r);
        if (!(f3 == 3'd0 || (f3 == 3'd1 && f7 == 7'd0) ||
              (f3 == 3'd5 && (f7 == 7'd0 || f7 == 7'h20)))) bad = 1'b1;
      end
      OPC_OP: begin
        has_rd = 1'b1; r64 = alu_r;
        if (f7 == 7'd1) is_md = 1'b1;
        else if (!(f7 == 7'd0 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))) bad = 1'b1;
      end
      OPC_OPW: begin
        has_rd = 1'b1;
        if (f3 == 3'd5 && f7 == 7'h20) r64 = sext32(64'($signed(sext32(a)) >>> sh));
        else if (f3 == 3'd5) r64 = sext32({32'd0, a[31:0]} >> sh);
        else r64 = sext32(alu_r);
        if (f7 == 7'd1) begin
          is_md = 1'b1;
          if (f3 != 3'd0 && !f3[2]) bad = 1'b1;
        end else if (!((f3 == 3'd0 && (f7 == 7'd0 || f7 == 7'h20)) ||
                       (f3 == 3'd1 && f7 == 7'd0) ||
                       (f3 == 3'd5 && (f7 == 7'd0 || f7 == 7'h20)))) bad = 1'b1;
      end
      OPC_SYSTEM: begin
        if (w == 32'h0000_0073) res_next.kind = KIND_ECALL;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      res_next = '0;
      res_next.kind = KIND_ILLEGAL;
      res_next.next_address = prog_counter;
      has_rd = 1'b0;
      is_md = 1'b0;
    end
    if (has_rd && w[11:7] != 5'd0 && 32'(w[11:7]) < REG_COUNT) begin
      res_next.dest_write = 1'b1;
      res_next.dest_index = w[11:7];
      res_next.dest_value = r64;
    end
  end

  // operand preparation for the shared unit: magnitudes for signed divide forms
  logic [63:0] sa, sb, ua, ub;
  logic        na, nb, sgn_div, div_form;
  always_comb begin
    md_w    = opc == OPC_OPW;
    sa      = md_w ? sext32(a) : a;
    sb      = md_w ? sext32(b) : b;
    if (md_w && f3[0]) begin sa = {32'd0, a[31:0]}; sb = {32'd0, b[31:0]}; end
    div_form = f3[2];
    sgn_div = div_form && !f3[0];
    na = sgn_div && sa[63];
    nb = sgn_div && sb[63];
    ua = na ? 64'd0 - sa : sa;
    ub = nb ? 64'd0 - sb : sb;
  end

  // fix-up of the unit's answer
  logic [63:0] md_res, q, r, hi;
  logic        md_bz, md_rem, md_asgn, md_bsgn;
  logic [63:0] md_ao, md_bo;
  always_comb begin
    q  = md_neg ? 64'd0 - md_rsp.lo : md_rsp.lo;
    r  = md_asgn ? 64'd0 - md_rsp.hi : md_rsp.hi;
    hi = md_rsp.hi - (md_asgn ? md_bo : 64'd0) - (md_bsgn ? md_ao : 64'd0);
    if (md_bz) md_res = md_rem ? md_ao : '1;
    else if (md_rem) md_res = r;
    else md_res = q;
    if (md_hi) md_res = hi;
  end

  logic [2:0] md_f3;
  logic [63:0] md_final;
  always_comb begin
    case (md_f3)
      3'd0: md_final = md_rsp.lo;
      3'd1, 3'd2, 3'd3: md_final = md_res;
      default: md_final = md_res;
    endcase
    if (md_w) md_final = sext32(md_final);
  end

  always_comb begin
    md_req.start = (state == ST_EXEC) && !op && is_md;
    md_req.mode  = div_form ? (sgn_div ? MD_DIVS : MD_DIVU) : MD_MUL;
    md_req.a     = div_form ? ua : a;
    md_req.b     = div_form ? ub : b;
    rf_we    = 1'b0;
    rf_waddr = rd[REG_AW-1:0];
    rf_wdata = res_next.dest_value;
    if (state == ST_CLEAR) begin
      rf_we = 1'b1; rf_waddr = clr_idx; rf_wdata = 64'd0;
    end else if (state == ST_EXEC && op && load_pending) begin
      rf_we = pending_dest != 5'd0 && 32'(pending_dest) < REG_COUNT;
      rf_waddr = pending_dest[REG_AW-1:0];
      rf_wdata = ((ldata & size_mask(pending_size)) ^ ldmsb) - ldmsb;
    end else if (state == ST_EXEC && !op && !is_md) begin
      rf_we = res_next.dest_write;
    end else if (state == ST_MD && md_rsp.done) begin
      rf_we = res.dest_write;
      rf_waddr = res.dest_index[REG_AW-1:0];
      rf_wdata = md_final;
    end
  end

  // result of a load return item
  always_comb begin
    res_ld = '0;
    res_ld.next_address = prog_counter;
    if (!load_pending) begin
      res_ld.kind = KIND_ILLEGAL;
    end else if (pending_dest != 5'd0 && 32'(pending_dest) < REG_COUNT) begin
      res_ld.dest_write = 1'b1;
      res_ld.dest_index = pending_dest;
      res_ld.dest_value = rf_wdata;
    end
  end

  always_comb begin
    ldmsb = 64'd0;
    if (pending_signed) begin
      case (pending_size)
        2'd0: ldmsb = 64'h80;
        2'd1: ldmsb = 64'h8000;
        2'd2: ldmsb = 64'h8000_0000;
        default: ldmsb = 64'd0;
      endcase
    end
  end

  assign in_ch.ready  = state == ST_IDLE;
  assign out_ch.valid = state == ST_OUT;
  assign out_ch.kind = res.kind;
  assign out_ch.mem_address = res.mem_address;
  assign out_ch.mem_size = res.mem_size;
  assign out_ch.store_value = res.store_value;
  assign out_ch.dest_write = res.dest_write;
  assign out_ch.dest_index = res.dest_index;
  assign out_ch.dest_value = res.dest_value;
  assign out_ch.next_address = res.next_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      start_address <= 64'd0;
      prog_counter <= 64'd0;
      load_pending <= 1'b0;
      pending_dest <= '0;
      pending_size <= '0;
      pending_signed <= 1'b0;
    end else begin
      if (cfg_wr) begin
        start_address <= pwdata;
        prog_counter <= pwdata;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == REG_COUNT - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            op <= in_ch.op; w <= in_ch.instr_word; ldata <= in_ch.load_data;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EXEC;
        ST_EXEC: begin
          if (op) begin
            res <= res_ld;
            load_pending <= 1'b0;
            state <= ST_OUT;
          end else begin
            res <= res_next;
            prog_counter <= res_next.next_address;
            load_pending <= res_next.kind == KIND_LOAD;
            if (res_next.kind == KIND_LOAD) begin
              pending_dest <= w[11:7];
              pending_size <= f3[1:0];
              pending_signed <= !f3[2];
            end
            md_f3 <= f3; md_hi <= !div_form && f3 != 3'd0;
            md_neg <= na ^ nb; md_asgn <= div_form ? na : (f3 != 3'd3 && a[63]);
            md_bsgn <= !div_form && f3 == 3'd1 && b[63];
            md_ao <= div_form ? sa : a; md_bo <= div_form ? sb : b;
            md_bz <= sb == 64'd0; md_rem <= f3[1];
            state <= is_md ? ST_MD : ST_OUT;
          end
        end
        ST_MD: begin
          if (md_rsp.done) begin
            res.dest_value <= res.dest_write ? md_final : 64'd0;
            state <= ST_OUT;
          end
        end
        ST_OUT: if (out_ch.ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### verif/tb_rv64im_integer_execute.sv
// Self-checking testbench for the RV64IM integer execute block.
`timescale 1ns / 1ps
module tb_rv64im_integer_execute;
  import rv64_pkg::*;

  localparam logic [2:0] F3_ADD = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SRL = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_MUL = 3'd0, F3_MULH = 3'd1, F3_MULHSU = 3'd2, F3_MULHU = 3'd3;
  localparam logic [2:0] F3_DIV = 3'd4, F3_DIVU = 3'd5, F3_REM = 3'd6, F3_REMU = 3'd7;
  localparam logic [2:0] F3_LB = 3'd0, F3_LWU = 3'd6, F3_LD = 3'd3, F3_BAD_LOAD = 3'd7;
  localparam logic [2:0] F3_SB = 3'd0, F3_SD = 3'd3;
  localparam logic [6:0] F7_BASE = 7'h00, F7_ALT = 7'h20, F7_MULDIV = 7'h01;
  localparam logic [5:0] SHT_LOGIC = 6'h00, SHT_ARITH = 6'h10;
  localparam logic [31:0] WORD_ECALL = 32'h0000_0073, WORD_EBREAK = 32'h0010_0073;
  localparam logic [3:0] ADDR_START = 4'd0;
  localparam bit OP_INSTR = 1'b0, OP_LDATA = 1'b1;
  localparam logic [63:0] ALL1 = '1, SBIT = 64'h8000_0000_0000_0000;

  typedef struct {
    bit          op;
    logic [31:0] word;
    logic [63:0] data;
  } exec_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  rv64_in_if in_ch();
  rv64_out_if out_ch();

  rv64im_integer_execute u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  exec_item_t pending_items[$];
  res_t       expected_results[$];
  int         err_count = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;

  // architectural state mirror
  logic [63:0] gpr[32];
  logic [63:0] pc_mirror = '0;
  bit          ld_wait = 1'b0;
  logic [4:0]  ld_dest = '0;
  logic [1:0]  ld_size = '0;
  bit          ld_sgn = 1'b0;

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
  end

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] gpr_read(input logic [4:0] i);
    return (i == 5'd0) ? 64'd0 : gpr[i];
  endfunction

  function automatic logic [63:0] int_alu(input logic [2:0] f3, input bit alt,
                                          input logic [63:0] a, input logic [63:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[5:0];
      F3_SLT:  return {63'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {63'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SRL:  return alt ? 64'($signed(a) >>> b[5:0]) : a >> b[5:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [63:0] quot_rem(input bit sgn, input bit rem,
                                           input logic [63:0] a, input logic [63:0] b);
    logic signed [63:0] sa, sb;
    sa = a;
    sb = b;
    if (b == 0) return rem ? a : ALL1;
    if (!sgn) return rem ? a % b : a / b;
    if (a == SBIT && b == ALL1) return rem ? 64'd0 : SBIT;
    return rem ? 64'(sa % sb) : 64'(sa / sb);
  endfunction

  function automatic logic [63:0] muldiv(input logic [2:0] f3,
                                         input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    case (f3)
      F3_MUL:    return a * b;
      F3_MULH:   p = {{64{a[63]}}, a} * {{64{b[63]}}, b};
      F3_MULHSU: p = {{64{a[63]}}, a} * {64'd0, b};
      F3_MULHU:  p = {64'd0, a} * {64'd0, b};
      F3_DIV:    return quot_rem(1'b1, 1'b0, a, b);
      F3_DIVU:   return quot_rem(1'b0, 1'b0, a, b);
      F3_REM:    return quot_rem(1'b1, 1'b1, a, b);
      default:   return quot_rem(1'b0, 1'b1, a, b);
    endcase
    return p[127:64];
  endfunction

  // Execute one item against the mirror and return the result it should give.
  function automatic res_t execute_item(input bit opv, input logic [31:0] w,
                                        input logic [63:0] ld);
    res_t r;
    logic [63:0] a, b, imm_i, imm_s, imm_b, imm_u, imm_j, res, nxt;
    logic [6:0] opc, f7;
    logic [2:0] f3;
    logic [4:0] rd, sh5;
    logic [5:0] sh6;
    bit has_rd, bad, taken;
    r = '0;
    res = '0;
    has_rd = 1'b0;
    bad = 1'b0;
    taken = 1'b0;
    rd = '0;
    if (opv) begin
      if (!ld_wait) begin
        r.kind = KIND_ILLEGAL;
      end else begin
        case (ld_size)
          2'd0: res = {{56{ld_sgn & ld[7]}}, ld[7:0]};
          2'd1: res = {{48{ld_sgn & ld[15]}}, ld[15:0]};
          2'd2: res = {{32{ld_sgn & ld[31]}}, ld[31:0]};
          default: res = ld;
        endcase
        rd = ld_dest;
        has_rd = 1'b1;
        ld_wait = 1'b0;
      end
    end else begin
      opc = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      a = gpr_read(w[19:15]);
      b = gpr_read(w[24:20]);
      imm_i = {{52{w[31]}}, w[31:20]};
      imm_s = {{52{w[31]}}, w[31:25], w[11:7]};
      imm_b = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      imm_u = {{32{w[31]}}, w[31:12], 12'd0};
      imm_j = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      sh6 = w[25:20];
      sh5 = w[24:20];
      ld_wait = 1'b0;
      rd = w[11:7];
      nxt = pc_mirror + 4;
      case (opc)
        OPC_LUI: begin
          res = imm_u; has_rd = 1'b1;
        end
        OPC_AUIPC: begin
          res = pc_mirror + imm_u; has_rd = 1'b1;
        end
        OPC_JAL: begin
          res = pc_mirror + 4; has_rd = 1'b1; nxt = pc_mirror + imm_j;
        end
        OPC_JALR: begin
          if (f3 != F3_ADD) bad = 1'b1;
          res = pc_mirror + 4; has_rd = 1'b1;
          nxt = (a + imm_i) & ~64'd1;
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  taken = a == b;
            F3_BNE:  taken = a != b;
            F3_BLT:  taken = $signed(a) < $signed(b);
            F3_BGE:  taken = $signed(a) >= $signed(b);
            F3_BLTU: taken = a < b;
            F3_BGEU: taken = a >= b;
            default: bad = 1'b1;
          endcase
          if (taken) nxt = pc_mirror + imm_b;
        end
        OPC_LOAD: begin
          if (f3 == F3_BAD_LOAD) begin
            bad = 1'b1;
          end else begin
            r.kind = KIND_LOAD;
            r.mem_address = a + imm_i;
            r.mem_size = f3[1:0];
            ld_wait = 1'b1;
            ld_dest = rd;
            ld_size = f3[1:0];
            ld_sgn = !f3[2];
          end
        end
        OPC_STORE: begin
          if (f3[2]) begin
            bad = 1'b1;
          end else begin
            r.kind = KIND_STORE;
            r.mem_address = a + imm_s;
            r.mem_size = f3[1:0];
            case (f3[1:0])
              2'd0: r.store_value = {56'd0, b[7:0]};
              2'd1: r.store_value = {48'd0, b[15:0]};
              2'd2: r.store_value = {32'd0, b[31:0]};
              default: r.store_value = b;
            endcase
          end
        end
        OPC_OPIMM: begin
          has_rd = 1'b1;
          if (f3 == F3_SLL) begin
            if (w[31:26] != SHT_LOGIC) bad = 1'b1;
            res = a << sh6;
          end else if (f3 == F3_SRL) begin
            if (w[31:26] == SHT_LOGIC) res = a >> sh6;
            else if (w[31:26] == SHT_ARITH) res = $signed(a) >>> sh6;
            else bad = 1'b1;
          end else begin
            res = int_alu(f3, 1'b0, a, imm_i);
          end
        end
        OPC_OPIMMW: begin
          has_rd = 1'b1;
          if (f3 == F3_ADD) res = sx32(a + imm_i);
          else if (f3 == F3_SLL && f7 == F7_BASE) res = sx32(a << sh5);
          else if (f3 == F3_SRL && f7 == F7_BASE) res = sx32({32'd0, a[31:0]} >> sh5);
          else if (f3 == F3_SRL && f7 == F7_ALT) res = sx32(64'($signed(a[31:0]) >>> sh5));
          else bad = 1'b1;
        end
        OPC_OP: begin
          has_rd = 1'b1;
          if (f7 == F7_MULDIV) res = muldiv(f3, a, b);
          else if (f7 == F7_BASE) res = int_alu(f3, 1'b0, a, b);
          else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SRL)) res = int_alu(f3, 1'b1, a, b);
          else bad = 1'b1;
        end
        OPC_OPW: begin
          has_rd = 1'b1;
          if (f7 == F7_MULDIV) begin
            case (f3)
              F3_MUL:  res = sx32(a * b);
              F3_DIV:  res = sx32(quot_rem(1'b1, 1'b0, sx32(a), sx32(b)));
              F3_DIVU: res = sx32(quot_rem(1'b0, 1'b0, {32'd0, a[31:0]}, {32'd0, b[31:0]}));
              F3_REM:  res = sx32(quot_rem(1'b1, 1'b1, sx32(a), sx32(b)));
              F3_REMU: res = sx32(quot_rem(1'b0, 1'b1, {32'd0, a[31:0]}, {32'd0, b[31:0]}));
              default: bad = 1'b1;
            endcase
          end else if (f3 == F3_ADD && (f7 == F7_BASE || f7 == F7_ALT)) begin
            res = sx32(f7 == F7_ALT ? a - b : a + b);
          end else if (f3 == F3_SLL && f7 == F7_BASE) begin
            res = sx32(a << b[4:0]);
          end else if (f3 == F3_SRL && f7 == F7_BASE) begin
            res = sx32({32'd0, a[31:0]} >> b[4:0]);
          end else if (f3 == F3_SRL && f7 == F7_ALT) begin
            res = sx32(64'($signed(a[31:0]) >>> b[4:0]));
          end else begin
            bad = 1'b1;
          end
        end
        OPC_SYSTEM: begin
          if (w == WORD_ECALL) r.kind = KIND_ECALL;
          else bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        r.kind = KIND_ILLEGAL;
        r.mem_address = '0;
        r.mem_size = '0;
        r.store_value = '0;
        has_rd = 1'b0;
        ld_wait = 1'b0;
        nxt = pc_mirror;
      end
      pc_mirror = nxt;
    end
    if (has_rd && rd != 5'd0) begin
      gpr[rd] = res;
    end else begin
      has_rd = 1'b0;
      rd = '0;
      res = '0;
    end
    r.dest_write = has_rd;
    r.dest_index = rd;
    r.dest_value = res;
    r.next_address = pc_mirror;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // input driver: hold valid until taken, record the expectation on acceptance
  always @(posedge clk) begin
    exec_item_t it;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= 1'b0;
      in_ch.instr_word <= '0;
      in_ch.load_data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(execute_item(in_ch.op, in_ch.instr_word,
                                                in_ch.load_data));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          it = pending_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= it.op;
          in_ch.instr_word <= it.word;
          in_ch.load_data <= it.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, kind", out_ch.kind, '0);
      end else begin
        want = expected_results.pop_front();
        check_field("kind", out_ch.kind, want.kind);
        check_field("mem_address", out_ch.mem_address, want.mem_address);
        check_field("mem_size", out_ch.mem_size, want.mem_size);
        check_field("store_value", out_ch.store_value, want.store_value);
        check_field("dest_write", out_ch.dest_write, want.dest_write);
        check_field("dest_index", out_ch.dest_index, want.dest_index);
        check_field("dest_value", out_ch.dest_value, want.dest_value);
        check_field("next_address", out_ch.next_address, want.next_address);
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  task automatic add_item(input bit opv, input logic [31:0] w, input logic [63:0] d);
    exec_item_t it;
    it.op = opv;
    it.word = w;
    it.data = d;
    pending_items.push_back(it);
  endtask

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  // Mostly well-formed instructions over a few registers; loads usually get their data.
  task automatic add_random_item();
    logic [31:0] w, rnd;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    int cls;
    rnd = $urandom;
    rd = pick_reg();
    rs1 = pick_reg();
    rs2 = pick_reg();
    f3 = 3'($urandom);
    cls = $urandom_range(0, 99);
    if (cls < 8) begin
      w = {rnd[31:12], rd, rnd[0] ? OPC_LUI : OPC_AUIPC};
    end else if (cls < 12) begin
      w = rnd[0] ? {rnd[31:12], rd, OPC_JAL}
                 : enc_i(rnd[31:20], rs1, rnd[1] ? F3_ADD : f3, rd, OPC_JALR);
    end else if (cls < 20) begin
      w = {rnd[31:25], rs2, rs1, f3, rnd[11:7], OPC_BRANCH};
    end else if (cls < 31) begin
      w = enc_i(rnd[31:20], rs1, f3, rd, OPC_LOAD);
      add_item(OP_INSTR, w, {$urandom, $urandom});
      if ($urandom_range(0, 9) != 0) add_item(OP_LDATA, $urandom, {$urandom, $urandom});
      return;
    end else if (cls < 38) begin
      w = {rnd[31:25], rs2, rs1, 1'b0, f3[1:0], rnd[11:7], OPC_STORE};
    end else if (cls < 54) begin
      w = enc_i(rnd[31:20], rs1, f3, rd, OPC_OPIMM);
      if (f3 == F3_SLL) w[31:26] = SHT_LOGIC;
      if (f3 == F3_SRL) w[31:26] = rnd[31] ? SHT_ARITH : SHT_LOGIC;
    end else if (cls < 61) begin
      case (rnd[1:0])
        2'd0: w = enc_i(rnd[31:20], rs1, F3_ADD, rd, OPC_OPIMMW);
        2'd1: w = enc_r(F7_BASE, rnd[24:20], rs1, F3_SLL, rd, OPC_OPIMMW);
        default: w = enc_r(rnd[2] ? F7_ALT : F7_BASE, rnd[24:20], rs1, F3_SRL, rd, OPC_OPIMMW);
      endcase
    end else if (cls < 80) begin
      case (rnd[1:0])
        2'd0, 2'd1: w = enc_r(F7_MULDIV, rs2, rs1, f3, rd, OPC_OP);
        2'd2: w = enc_r(F7_BASE, rs2, rs1, f3, rd, OPC_OP);
        default: w = enc_r(F7_ALT, rs2, rs1, rnd[2] ? F3_SRL : F3_ADD, rd, OPC_OP);
      endcase
    end else if (cls < 90) begin
      w = enc_r(rnd[0] ? F7_MULDIV : (rnd[1] ? F7_ALT : F7_BASE), rs2, rs1, f3, rd, OPC_OPW);
    end else if (cls < 92) begin
      w = WORD_ECALL;
    end else if (cls < 94) begin
      add_item(OP_LDATA, $urandom, {$urandom, $urandom});
      return;
    end else begin
      w = rnd;
    end
    add_item(OP_INSTR, w, {$urandom, $urandom});
  endtask

  task automatic add_directed();
    add_item(OP_INSTR, enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM), '0);     // x2 = -1
    add_item(OP_INSTR, {20'h80000, 5'd1, OPC_LUI}, '1);
    add_item(OP_INSTR, enc_i(12'd32, 5'd1, F3_SLL, 5'd1, OPC_OPIMM), '0);      // x1 = min
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd3, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd3, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd0, 5'd2, F3_DIVU, 5'd3, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd0, 5'd2, F3_REMU, 5'd4, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd5, OPC_OP), '0);
    add_item(OP_INSTR, {20'h80000, 5'd6, OPC_LUI}, '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd6, F3_DIV, 5'd7, OPC_OPW), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd6, F3_REM, 5'd7, OPC_OPW), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd0, 5'd6, F3_DIVU, 5'd7, OPC_OPW), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd8, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MULHSU, 5'd8, OPC_OP), '0);
    add_item(OP_INSTR, enc_r(F7_MULDIV, 5'd2, 5'd2, F3_MULHU, 5'd8, OPC_OP), '0);
    add_item(OP_INSTR, enc_i(12'h7FF, 5'd2, F3_LB, 5'd9, OPC_LOAD), '0);
    add_item(OP_LDATA, '1, 64'h0123_4567_89AB_CD80);
    add_item(OP_INSTR, enc_i(12'h800, 5'd1, F3_LWU, 5'd9, OPC_LOAD), '0);
    add_item(OP_LDATA, '0, 64'hFFFF_FFFF_8000_0001);
    add_item(OP_INSTR, enc_i(12'd8, 5'd2, F3_LD, 5'd10, OPC_LOAD), '0);
    add_item(OP_INSTR, enc_r(F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_OP), '0);    // abandons load
    add_item(OP_LDATA, '0, '1);                                                  // nothing pending
    add_item(OP_INSTR, {7'h7F, 5'd2, 5'd1, 1'b0, F3_SD[1:0], 5'h1F, OPC_STORE}, '0);
    add_item(OP_INSTR, {7'h00, 5'd2, 5'd0, 1'b0, F3_SB[1:0], 5'h00, OPC_STORE}, '0);
    add_item(OP_INSTR, enc_i(12'h001, 5'd0, F3_BAD_LOAD, 5'd3, OPC_LOAD), '0);
    add_item(OP_INSTR, WORD_ECALL, '0);
    add_item(OP_INSTR, WORD_EBREAK, '0);
    add_item(OP_INSTR, '0, '0);
    add_item(OP_INSTR, enc_i(12'd0, 5'd2, F3_ADD, 5'd11, OPC_JALR), '0);        // odd target
  endtask

  task automatic wait_drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_start(input logic [63:0] value);
    wait_drain();
    repeat (80) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_START;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pc_mirror = value;
  endtask

  task automatic run_phase(input logic [63:0] start, input int snd, input int rcv,
                           input int count);
    write_start(start);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    repeat (count / 2) add_random_item();
    // hold the sender until everything issued so far has come back
    wait_drain();
    repeat (count - count / 2) add_random_item();
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_start('0);
    add_directed();
    wait_drain();
    run_phase(64'h0000_0000_0000_1000, 0, 0, 200);
    run_phase(64'hFFFF_FFFF_FFFF_FFFC, 58, 0, 200);
    run_phase({$urandom, $urandom}, 0, 58, 200);
    run_phase(ALL1, 7, 7, 200);
    run_phase(64'h7FFF_FFFF_FFFF_FFF0, 0, 0, 200);
    repeat (100) @(posedge clk);
    if (expected_results.size() > 0)
      report_mismatch("items still awaited", expected_results.size(), '0);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
